@@ rtl/dual_stack_shared_array_assert.svh @@
// Assertion macros for the dual stack block
`ifndef DUAL_STACK_SHARED_ARRAY_ASSERT_SVH
`define DUAL_STACK_SHARED_ARRAY_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define DSSA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define DSSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/dssa_pkg.sv @@
package dssa_pkg;

    // Store geometry
    localparam int DEPTH = 256;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = AW + 1;
    localparam int DW    = 32;

    // Operation codes
    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_POP    = 3'd1;
    localparam logic [2:0] OP_PEEK   = 3'd2;
    localparam logic [2:0] OP_SEARCH = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // Input beat
    typedef struct packed {
        logic [2:0]           operation;
        logic                 which_stack;
        logic signed [DW-1:0] value;
    } t_cmd;

    // Result beat
    typedef struct packed {
        logic [1:0]           status;
        logic signed [DW-1:0] data;
        logic [AW-1:0]        found_slot;
        logic [CW-1:0]        count_up;
        logic [CW-1:0]        count_down;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic       latch;
        logic       push_wr;
        logic       rd_top;
        logic       scan_first;
        logic       scan_next;
        logic       pop_dec;
        logic       clr_all;
        logic       finish;
        logic [1:0] fin_status;
        logic       take_data;
        logic       take_slot;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] op;
        logic       full;
        logic       empty;
        logic       match;
        logic       last;
    } t_dp_stat;

endpackage

@@ rtl/dssa_ram.sv @@
module dssa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/dssa_ctrl.sv @@
module dssa_ctrl
    import dssa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_dp_stat  i_stat,
    output logic      o_busy,
    output t_ctrl_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_SCAN = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Sequencer
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.fin_status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                unique case (i_stat.op)
                    OP_PUSH: begin
                        o_cmd.finish = 1'b1;
                        if (i_stat.full) begin
                            o_cmd.fin_status = ST_FULL;
                        end else begin
                            o_cmd.push_wr = 1'b1;
                        end
                    end
                    OP_POP, OP_PEEK: begin
                        if (i_stat.empty) begin
                            o_cmd.finish     = 1'b1;
                            o_cmd.fin_status = ST_EMPTY;
                        end else begin
                            o_cmd.rd_top = 1'b1;
                            n_state      = S_READ;
                        end
                    end
                    OP_SEARCH: begin
                        if (i_stat.empty) begin
                            o_cmd.finish     = 1'b1;
                            o_cmd.fin_status = ST_NOTFOUND;
                        end else begin
                            o_cmd.scan_first = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.clr_all = 1'b1;
                        o_cmd.finish  = 1'b1;
                    end
                    default: begin
                        // unused codes: plain OK, nothing changes
                        o_cmd.finish = 1'b1;
                    end
                endcase
            end
            S_READ: begin
                o_cmd.finish    = 1'b1;
                o_cmd.take_data = 1'b1;
                o_cmd.pop_dec   = (i_stat.op == OP_POP);
                n_state         = S_IDLE;
            end
            S_SCAN: begin
                priority if (i_stat.match) begin
                    o_cmd.finish    = 1'b1;
                    o_cmd.take_slot = 1'b1;
                    n_state         = S_IDLE;
                end else if (i_stat.last) begin
                    o_cmd.finish     = 1'b1;
                    o_cmd.fin_status = ST_NOTFOUND;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

@@ rtl/dssa_dp.sv @@
module dssa_dp
    import dssa_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [CW-1:0] i_cfg_data,
    input  t_cmd          i_cmd_in,
    input  t_ctrl_cmd     i_ctl,
    output t_dp_stat      o_stat,
    output logic          o_done,
    output t_result       o_result
);

    logic [CW-1:0] r_cap;
    logic [CW-1:0] r_up;
    logic [CW-1:0] r_dn;
    logic [CW-1:0] n_up;
    logic [CW-1:0] n_dn;
    t_cmd          r_cmd;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] n_idx;
    t_result       r_result;
    logic          r_done;

    logic [CW-1:0] eff_cap;
    logic [CW-1:0] cnt_sel;
    logic [CW-1:0] sel_i;
    logic [CW-1:0] slot;
    logic [CW-1:0] scan_slot;
    logic [CW:0]   used;
    logic          ram_re;
    logic [DW-1:0] ram_rdata;

    // Slot of the i-th entry from the bottom of the selected stack
    function automatic logic [CW-1:0] slot_of(input logic down, input logic [CW-1:0] cap,
                                              input logic [CW-1:0] i);
        return down ? (cap - CW'(1) - i) : i;
    endfunction

    // Effective capacity: clamp into one..DEPTH
    always_comb begin
        priority if (r_cap == '0) begin
            eff_cap = CW'(1);
        end else if (r_cap > CW'(DEPTH)) begin
            eff_cap = CW'(DEPTH);
        end else begin
            eff_cap = r_cap;
        end
    end

    // Address selection
    always_comb begin
        cnt_sel = r_cmd.which_stack ? r_dn : r_up;
        priority if (i_ctl.push_wr) begin
            sel_i = cnt_sel;
        end else if (i_ctl.rd_top) begin
            sel_i = cnt_sel - CW'(1);
        end else if (i_ctl.scan_next) begin
            sel_i = {1'b0, r_idx} + CW'(1);
        end else begin
            sel_i = '0;
        end
        slot      = slot_of(r_cmd.which_stack, eff_cap, sel_i);
        scan_slot = slot_of(r_cmd.which_stack, eff_cap, {1'b0, r_idx});
        used      = {1'b0, r_up} + {1'b0, r_dn};
    end

    assign ram_re = i_ctl.rd_top | i_ctl.scan_first | i_ctl.scan_next;

    dssa_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.push_wr),
        .i_re    (ram_re),
        .i_addr  (slot[AW-1:0]),
        .i_wdata (r_cmd.value),
        .o_rdata (ram_rdata)
    );

    // Status to controller
    always_comb begin
        o_stat.op    = r_cmd.operation;
        o_stat.full  = (used >= {1'b0, eff_cap});
        o_stat.empty = (cnt_sel == '0);
        o_stat.match = (ram_rdata == r_cmd.value);
        o_stat.last  = (({1'b0, r_idx} + CW'(1)) == cnt_sel);
    end

    // Next counts and scan index
    always_comb begin
        n_up  = r_up;
        n_dn  = r_dn;
        n_idx = r_idx;
        priority if (i_cfg_we || i_ctl.clr_all) begin
            n_up = '0;
            n_dn = '0;
        end else if (i_ctl.push_wr) begin
            if (r_cmd.which_stack) begin
                n_dn = r_dn + CW'(1);
            end else begin
                n_up = r_up + CW'(1);
            end
        end else if (i_ctl.pop_dec) begin
            if (r_cmd.which_stack) begin
                n_dn = r_dn - CW'(1);
            end else begin
                n_up = r_up - CW'(1);
            end
        end else begin
            n_up = r_up;
        end
        priority if (i_ctl.scan_first) begin
            n_idx = '0;
        end else if (i_ctl.scan_next) begin
            n_idx = r_idx + AW'(1);
        end else begin
            n_idx = r_idx;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= CW'(DEPTH);
            r_up   <= '0;
            r_dn   <= '0;
            r_done <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            r_up   <= n_up;
            r_dn   <= n_dn;
            r_done <= i_ctl.finish;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_ctl.latch) begin
            r_cmd <= i_cmd_in;
        end
        if (i_ctl.finish) begin
            r_result.status     <= i_ctl.fin_status;
            r_result.data       <= i_ctl.take_data ? ram_rdata : '0;
            r_result.found_slot <= i_ctl.take_slot ? scan_slot[AW-1:0] : '0;
            r_result.count_up   <= n_up;
            r_result.count_down <= n_dn;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

@@ rtl/dual_stack_shared_array.sv @@
// Channel  | Ports                        | Handshake
// ---------+------------------------------+-------------------------------------
// command  | i_cmd (t_cmd)                | taken when start high and busy low
// result   | o_result (t_result)          | valid for one cycle with o_done
// config   | i_cfg_data                   | written when i_cfg_we high
//
// From accept to result strobe: push, clear and failed ops finish in the execute state;
// pop and peek pass through the read state; search stays in the scan state until a match
// or the last entry of the stack, one slot compared per cycle from the single-port store.
// A new beat can be taken in the cycle that o_done shows the previous result.
// Reset (i_rst_n low, synchronous) empties both stacks and sets capacity to DEPTH.
// The result side cannot stall; each result is shown for exactly one cycle.
`include "dual_stack_shared_array_assert.svh"

module dual_stack_shared_array
    import dssa_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  t_cmd          i_cmd,
    input  logic          i_cfg_we,
    input  logic [CW-1:0] i_cfg_data,
    output logic          o_done,
    output t_result       o_result
);

    t_ctrl_cmd ctl;
    t_dp_stat  stat;

    dssa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_cmd   (ctl)
    );

    dssa_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd_in   (i_cmd),
        .i_ctl      (ctl),
        .o_stat     (stat),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    // Checks
    `DSSA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
    `DSSA_ASSERT_NOW(a_done_idle, o_done, !busy, "result strobe while still busy")
    `DSSA_ASSERT_NEXT(a_done_single, o_done, !o_done, "result strobe held two cycles")
    `DSSA_ASSERT_NOW(a_count_bound, o_done, ({1'b0, o_result.count_up} + {1'b0, o_result.count_down}) <= (CW + 1)'(DEPTH), "stack counts exceed store depth")

endmodule
